### rtl/core/scd_pkg.sv
package scd_pkg;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [15:0] DEPTH_MAX = 16'd61440;
  localparam logic [16:0] MIX_MAX   = 17'd65536;

  typedef enum logic [1:0] {
    REG_LFO_STEP,
    REG_BASE_DELAY,
    REG_DEPTH,
    REG_MIX
  } scd_reg_t;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } scd_in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } scd_out_t;

  // register values as the datapath uses them (depth and mix already limited)
  typedef struct packed {
    logic [19:0] lfo_phase_step;
    logic [10:0] base_delay_samples;
    logic [15:0] depth_q6;
    logic [16:0] mix_q16;
  } scd_cfg_t;

  typedef struct packed {
    logic load_sine;
    logic load_mag;
    logic advance;
  } scd_lfo_ctrl_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic calc_wet;
    logic calc_prod;
    logic calc_sum;
  } scd_lane_ctrl_t;

endpackage

### rtl/core/scd_regs.sv
module scd_regs
  import scd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output scd_cfg_t          cfg
);

  logic [19:0] lfo_phase_step;
  logic [10:0] base_delay_samples;
  logic [15:0] depth_q6;
  logic [16:0] mix_q16;
  scd_reg_t    sel;

  assign sel    = scd_reg_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase_step     <= 20'd89478;
      base_delay_samples <= 11'd960;
      depth_q6           <= 16'd0;
      mix_q16            <= 17'd32768;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_LFO_STEP:   lfo_phase_step     <= pwdata[19:0];
        REG_BASE_DELAY: base_delay_samples <= pwdata[10:0];
        REG_DEPTH:      depth_q6           <= pwdata[15:0];
        REG_MIX:        mix_q16            <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LFO_STEP:   prdata = CFG_DW'(lfo_phase_step);
      REG_BASE_DELAY: prdata = CFG_DW'(base_delay_samples);
      REG_DEPTH:      prdata = CFG_DW'(depth_q6);
      REG_MIX:        prdata = CFG_DW'(mix_q16);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.lfo_phase_step     = lfo_phase_step;
    cfg.base_delay_samples = base_delay_samples;
    cfg.depth_q6           = (depth_q6 > DEPTH_MAX) ? DEPTH_MAX : depth_q6;
    cfg.mix_q16            = (mix_q16 > MIX_MAX) ? MIX_MAX : mix_q16;
  end

endmodule

### rtl/core/scd_lfo.sv
module scd_lfo
  import scd_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  scd_lfo_ctrl_t ctrl,
  input  logic [19:0]   step,
  input  logic [15:0]   depth,
  output logic [14:0]   mag,
  output logic          neg
);

  localparam int SW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = 33 + SW;

  function automatic logic signed [15:0] rom_sine(input int unsigned i);
    longint unsigned a64;
    int unsigned a, quad, x, x2, t, t2, s;
    a64  = (64'(i) * 64'd65536) / SINE_TABLE_DEPTH;
    a    = 32'(a64) & 32'hFFFF;
    quad = a >> 14;
    x    = a & 32'h3FFF;
    if (quad[0])
      x = 32'd16384 - x;
    x2 = (x * x) >> 14;
    t  = 32'd21024 - ((x2 * 32'd2320) >> 14);
    t2 = 32'd51472 - ((x2 * t) >> 14);
    s  = (x * t2) >> 14;
    if (s > 32'd32767)
      s = 32'd32767;
    return quad[1] ? 16'(32'd0 - s) : 16'(s);
  endfunction

  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = rom_sine(32'(g));
  end

  logic [31:0]        lfo_phase;
  logic [PW-1:0]      idx_prod;
  logic [SW-1:0]      idx;
  logic signed [15:0] sine;
  logic [14:0]        sine_abs;
  logic [31:0]        scaled;

  assign idx_prod = PW'(lfo_phase) * PW'(SINE_TABLE_DEPTH);
  assign sine_abs = sine[15] ? 15'(-sine) : sine[14:0];
  assign scaled   = 32'(depth) * 32'(sine_abs) + 32'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase <= '0;
      idx       <= '0;
    end else begin
      // index follows the phase in the next cycle, well before the next word
      idx <= idx_prod[32 +: SW];
      if (ctrl.advance)
        lfo_phase <= lfo_phase + 32'(step);
    end
    if (ctrl.load_sine)
      sine <= sine_rom[idx];
    if (ctrl.load_mag) begin
      mag <= scaled[30:16];
      neg <= sine[15];
    end
  end

endmodule

### rtl/core/scd_delay_ram.sv
module scd_delay_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic signed [15:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic signed [15:0] rdata
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/scd_lane.sv
module scd_lane
  import scd_pkg::*;
(
  input  logic               clk,
  input  scd_lane_ctrl_t     ctrl,
  input  logic signed [15:0] tap,
  input  logic [5:0]         frac,
  input  logic signed [15:0] dry,
  input  logic [16:0]        mix,
  output logic signed [15:0] sample
);

  logic signed [15:0] a;
  logic signed [15:0] b;
  logic signed [22:0] wet;
  logic signed [33:0] p_dry;
  logic signed [40:0] p_wet;

  logic signed [7:0]  w0;
  logic signed [7:0]  w1;
  logic signed [17:0] inv_mix;
  logic signed [17:0] mix_s;
  logic signed [23:0] wet_sum;
  logic signed [41:0] acc;
  logic signed [19:0] r;
  logic signed [15:0] sat;

  assign w0      = signed'(8'd64 - 8'(frac));
  assign w1      = signed'(8'(frac));
  assign wet_sum = 24'(a * w0) + 24'(b * w1);
  assign inv_mix = signed'(18'd65536 - 18'(mix));
  assign mix_s   = signed'(18'(mix));
  assign acc     = (42'(p_dry) <<< 6) + 42'(p_wet) + 42'sd2097152;
  assign r       = acc[41:22];

  always_comb begin
    if (r > 20'sd32767)
      sat = 16'sh7FFF;
    else if (r < -20'sd32768)
      sat = 16'sh8000;
    else
      sat = r[15:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_a)
      a <= tap;
    if (ctrl.load_b)
      b <= tap;
    if (ctrl.calc_wet)
      wet <= wet_sum[22:0];
    if (ctrl.calc_prod) begin
      p_dry <= 34'(dry * inv_mix);
      p_wet <= 41'(wet * mix_s);
    end
    if (ctrl.calc_sum)
      sample <= sat;
  end

endmodule

### rtl/core/stereo_chorus_delay.sv
// Stereo chorus with a sine LFO and an interpolated modulated delay.
// Input channel dry_valid / dry_stall / dry_word carries one left and one right
// Q1.15 sample per word; output channel mix_valid / mix_stall / mix_word returns
// one mixed stereo word for each input word, in order.
// Each word runs through a ten-state sequencer: sine lookup, delay scaling,
// delay clamp, read address, two reads of each delay-line RAM (the older and
// the newer tap), write of the new samples, interpolation, mix products and
// rounding. The sequencer takes no new word until it is back in idle, which it
// reaches once the rounding step has passed its result to the output register.
// The result waits in an output register; while mix_stall is high the block
// holds it and parks the next word in the rounding step until it is taken.
// Reset (rst, synchronous) clears the LFO phase, the write pointer and the
// registers to their defaults. Delay-line entries not yet written since reset
// read as zero through a fill mark, so no clearing pass is needed.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12.
module stereo_chorus_delay
  import scd_pkg::*;
#(
  parameter int DELAY_DEPTH      = 2048,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              dry_valid,
  output logic              dry_stall,
  input  scd_in_t           dry_word,
  output logic              mix_valid,
  input  logic              mix_stall,
  output scd_out_t          mix_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int DW  = AW + 6;
  localparam int PSW = AW + 8;
  localparam int DLW = (((AW + 6) > 17) ? (AW + 6) : 17) + 2;

  localparam logic signed [DLW-1:0] DMAX = DLW'((DELAY_DEPTH - 2) * 64);
  localparam logic [PSW-1:0]        SPAN = PSW'(DELAY_DEPTH * 64);
  localparam logic [AW-1:0]         LAST = AW'(DELAY_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_DLY, S_POS, S_RD0, S_RD1, S_WR, S_WET, S_PROD, S_SUM
  } state_t;

  state_t         state;
  scd_cfg_t       cfg;
  scd_lfo_ctrl_t  lfo_ctrl;
  scd_lane_ctrl_t lane_ctrl;

  scd_in_t        dry_q;
  logic [DW-1:0]  dly;
  logic [AW-1:0]  i0;
  logic [AW-1:0]  i1;
  logic [5:0]     frac;
  logic           v0;
  logic           v1;
  logic [AW-1:0]  wp;
  logic           filled;

  logic [14:0]    mag;
  logic           neg;

  logic                  dry_acc;
  logic                  out_free;
  logic                  mix_valid_next;
  logic signed [DLW-1:0] base_ext;
  logic signed [DLW-1:0] mag_ext;
  logic signed [DLW-1:0] delay_raw;
  logic [DW-1:0]         dly_next;
  logic [PSW-1:0]        pos_raw;
  logic [PSW-1:0]        pos;
  logic [AW-1:0]         i0_next;
  logic [AW-1:0]         i1_next;

  logic [AW-1:0]      raddr;
  logic               ram_we;
  logic signed [15:0] rd_l;
  logic signed [15:0] rd_r;
  logic               tap_ok;
  logic signed [15:0] tap_l;
  logic signed [15:0] tap_r;

  assign dry_stall = (state != S_IDLE);
  assign dry_acc   = dry_valid && !dry_stall;
  assign out_free  = !mix_valid || !mix_stall;

  // modulated delay in 1/64 samples, limited to the line
  assign base_ext  = signed'(DLW'({cfg.base_delay_samples, 6'b0}));
  assign mag_ext   = signed'(DLW'(mag));
  assign delay_raw = neg ? (base_ext - mag_ext) : (base_ext + mag_ext);

  always_comb begin
    if (delay_raw > DMAX)
      dly_next = DMAX[DW-1:0];
    else if (delay_raw < 0)
      dly_next = '0;
    else
      dly_next = delay_raw[DW-1:0];
  end

  assign pos_raw = PSW'({wp, 6'b0}) + SPAN - PSW'(dly);
  assign pos     = (pos_raw >= SPAN) ? (pos_raw - SPAN) : pos_raw;
  assign i0_next = pos[6 +: AW];
  assign i1_next = (i0_next == LAST) ? '0 : (i0_next + 1'b1);

  assign raddr  = (state == S_RD0) ? i0 : i1;
  assign ram_we = (state == S_WR);

  // slots not yet written since reset read as zero
  assign tap_ok = (state == S_RD1) ? v0 : v1;
  assign tap_l  = tap_ok ? rd_l : 16'sd0;
  assign tap_r  = tap_ok ? rd_r : 16'sd0;

  always_comb begin
    lfo_ctrl.load_sine  = dry_acc;
    lfo_ctrl.load_mag   = (state == S_SCALE);
    lfo_ctrl.advance    = (state == S_WR);
    lane_ctrl.load_a    = (state == S_RD1);
    lane_ctrl.load_b    = (state == S_WR);
    lane_ctrl.calc_wet  = (state == S_WET);
    lane_ctrl.calc_prod = (state == S_PROD);
    lane_ctrl.calc_sum  = (state == S_SUM) && out_free;
  end

  // hold a waiting word, drop it once taken, raise on a fresh result
  always_comb begin
    mix_valid_next = mix_valid && mix_stall;
    if ((state == S_SUM) && out_free)
      mix_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      filled    <= 1'b0;
      mix_valid <= 1'b0;
    end else begin
      mix_valid <= mix_valid_next;
      case (state)
        S_IDLE: begin
          if (dry_acc)
            state <= S_SCALE;
        end
        S_SCALE: state <= S_DLY;
        S_DLY:   state <= S_POS;
        S_POS:   state <= S_RD0;
        S_RD0:   state <= S_RD1;
        S_RD1:   state <= S_WR;
        S_WR: begin
          wp <= (wp == LAST) ? '0 : (wp + 1'b1);
          if (wp == LAST)
            filled <= 1'b1;
          state <= S_WET;
        end
        S_WET:   state <= S_PROD;
        S_PROD:  state <= S_SUM;
        S_SUM: begin
          // hold here while the previous word is still waiting
          if (out_free)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    if (dry_acc)
      dry_q <= dry_word;
    if (state == S_DLY)
      dly <= dly_next;
    if (state == S_POS) begin
      i0   <= i0_next;
      i1   <= i1_next;
      frac <= pos[5:0];
      v0   <= filled || (i0_next < wp);
      v1   <= filled || (i1_next < wp);
    end
  end

  scd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scd_lfo #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lfo (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lfo_ctrl),
    .step  (cfg.lfo_phase_step),
    .depth (cfg.depth_q6),
    .mag   (mag),
    .neg   (neg)
  );

  scd_delay_ram #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_ram_l (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (dry_q.left_in),
    .raddr (raddr),
    .rdata (rd_l)
  );

  scd_delay_ram #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_ram_r (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (dry_q.right_in),
    .raddr (raddr),
    .rdata (rd_r)
  );

  scd_lane u_lane_l (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .tap    (tap_l),
    .frac   (frac),
    .dry    (dry_q.left_in),
    .mix    (cfg.mix_q16),
    .sample (mix_word.left_out)
  );

  scd_lane u_lane_r (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .tap    (tap_r),
    .frac   (frac),
    .dry    (dry_q.right_in),
    .mix    (cfg.mix_q16),
    .sample (mix_word.right_out)
  );

endmodule
